// ===== design/sat_pkg.sv =====
// shared constants and types for the scheduled action table
package sat_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int MAX_FIRE   = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FIRE_W     = $clog2(MAX_FIRE + 1);
    localparam int TIME_W     = 32;
    localparam int CODE_W     = 8;
    localparam int ENTRY_W    = TIME_W + CODE_W;

    localparam logic REQ_SCHEDULE = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SCAN      = 5'b00010,
        ST_SCAN_LAST = 5'b00100,
        ST_FIRE_RD   = 5'b01000,
        ST_FIRE_WAIT = 5'b10000
    } state_t;

endpackage

// ===== design/scheduled_action_table.sv =====
// scheduled action table: slot memory, tick scan and firing sequencer
//
// One input channel (in_valid / in_stall) takes schedule requests and time
// ticks; one output channel (out_valid / out_stall) gives acknowledgments
// and fired actions. Due times and codes sit in a synchronous slot memory;
// the active flags are flip-flops.
// The ack of a schedule request is registered at the edge that takes the
// request, so it appears in the next cycle, with last set.
// A synced tick scans the memory one slot per cycle to build the due mask,
// then fires due slots lowest first, each fired action by a memory read
// and then an output load, at most MAX_FIRE per tick.
// A tick with nothing due gives no output; an unsynced tick is ignored.
// The memory read port paces the scan: one slot is read per cycle.
// in_stall is high while a tick is in progress and while the output
// register holds a transfer that is not being taken.
// A stalled output holds its transfer and the sequencer waits for it.
// Reset clears all active flags at once; the memory needs no clearing.
module scheduled_action_table
    import sat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [CODE_W-1:0] action_code,
    input  logic [TIME_W-1:0] due_time,
    input  logic [TIME_W-1:0] current_time,
    input  logic              time_synced,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              result_kind,
    output logic              status,
    output logic [CODE_W-1:0] fired_action,
    output logic [2:0]        slot_index,
    output logic              last
);

    logic [ENTRY_W-1:0] slot_mem [SLOT_COUNT];

    state_t              state_reg, state_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_COUNT-1:0] mask_reg, mask_next;
    logic [SLOT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]   fire_idx_reg, fire_idx_next;
    logic [FIRE_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic                out_valid_reg, out_valid_next;
    logic                result_kind_reg, result_kind_next;
    logic                status_reg, status_next;
    logic [CODE_W-1:0]   fired_action_reg, fired_action_next;
    logic [2:0]          slot_index_reg, slot_index_next;
    logic                last_reg, last_next;

    logic                mem_we;
    logic [SLOT_W-1:0]   wr_addr;
    logic                mem_re;
    logic [SLOT_W-1:0]   rd_addr;

    logic                out_free;
    logic                in_accept;
    logic                table_full;
    logic [SLOT_W-1:0]   free_idx;
    logic                pick_found;
    logic [SLOT_W-1:0]   pick_idx;
    logic                due_hit;
    logic                fire_last;
    logic [SLOT_W+2:0]   idx_ext;

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        table_full = 1'b1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx   = SLOT_W'(i);
                table_full = 1'b0;
            end
        end
    end

    // lowest due slot still to fire
    always_comb
    begin
        pick_idx   = '0;
        pick_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_idx   = SLOT_W'(i);
                pick_found = 1'b1;
            end
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign due_hit   = cmp_valid_reg && active_reg[cmp_idx_reg]
                       && (now_reg >= rd_data_reg[TIME_W-1:0]);
    assign fire_last = (mask_reg == '0) || (count_reg == FIRE_W'(MAX_FIRE - 1));

    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        mask_next         = mask_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_valid_next    = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        fire_idx_next     = fire_idx_reg;
        count_next        = count_reg;
        now_next          = now_reg;
        mem_we            = 1'b0;
        wr_addr           = free_idx;
        mem_re            = 1'b0;
        rd_addr           = scan_idx_reg;
        out_valid_next    = out_valid_reg && out_stall;
        result_kind_next  = result_kind_reg;
        status_next       = status_reg;
        fired_action_next = fired_action_reg;
        slot_index_next   = slot_index_reg;
        last_next         = last_reg;
        idx_ext           = '0;

        if (due_hit)
        begin
            mask_next[cmp_idx_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_SCHEDULE)
                    begin
                        idx_ext           = {3'b000, free_idx};
                        out_valid_next    = 1'b1;
                        result_kind_next  = KIND_ACK;
                        fired_action_next = action_code;
                        last_next         = 1'b1;
                        if (table_full)
                        begin
                            status_next     = STATUS_FULL;
                            slot_index_next = '0;
                        end
                        else
                        begin
                            status_next           = STATUS_STORED;
                            slot_index_next       = idx_ext[2:0];
                            mem_we                = 1'b1;
                            active_next[free_idx] = 1'b1;
                        end
                    end
                    else if (time_synced)
                    begin
                        now_next      = current_time;
                        scan_idx_next = '0;
                        mask_next     = '0;
                        count_next    = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                mem_re         = 1'b1;
                rd_addr        = scan_idx_reg;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg;
                if (scan_idx_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_SCAN_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_FIRE_RD;
            end
            ST_FIRE_RD:
            begin
                if (pick_found && (count_reg != FIRE_W'(MAX_FIRE)))
                begin
                    mem_re                = 1'b1;
                    rd_addr               = pick_idx;
                    mask_next[pick_idx]   = 1'b0;
                    active_next[pick_idx] = 1'b0;
                    fire_idx_next         = pick_idx;
                    state_next            = ST_FIRE_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIRE_WAIT:
            begin
                if (out_free)
                begin
                    idx_ext           = {3'b000, fire_idx_reg};
                    out_valid_next    = 1'b1;
                    result_kind_next  = KIND_FIRE;
                    status_next       = STATUS_STORED;
                    fired_action_next = rd_data_reg[ENTRY_W-1:TIME_W];
                    slot_index_next   = idx_ext[2:0];
                    last_next         = fire_last;
                    count_next        = count_reg + 1'b1;
                    state_next        = fire_last ? ST_IDLE : ST_FIRE_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= {action_code, due_time};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg         <= mask_next;
        scan_idx_reg     <= scan_idx_next;
        cmp_idx_reg      <= cmp_idx_next;
        fire_idx_reg     <= fire_idx_next;
        count_reg        <= count_next;
        now_reg          <= now_next;
        result_kind_reg  <= result_kind_next;
        status_reg       <= status_next;
        fired_action_reg <= fired_action_next;
        slot_index_reg   <= slot_index_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = result_kind_reg;
    assign status       = status_reg;
    assign fired_action = fired_action_reg;
    assign slot_index   = slot_index_reg;
    assign last         = last_reg;

    // new items only while no tick is in progress
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> state_reg == ST_IDLE)
        else $error("input transfer taken while busy");

    // a stored request leaves its slot active
    a_store_active: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type == REQ_SCHEDULE && !table_full)
        |=> active_reg[$past(free_idx)])
        else $error("scheduled slot not active");

    // the slot being fired has already been released
    a_fire_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIRE_WAIT |-> !active_reg[fire_idx_reg])
        else $error("fired slot still active");

    // the final fired transfer ends the tick
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIRE_WAIT && out_free && fire_last)
        |=> (state_reg == ST_IDLE && last_reg))
        else $error("tick did not end on last transfer");

endmodule
